FILE: rtl/a2flv_pkg.sv
`default_nettype none

package a2flv_pkg;

    localparam int unsigned MaxResults = 6;

    localparam logic [7:0] SyncByte      = 8'hFF;
    localparam logic [7:0] SyncMask      = 8'hF6;
    localparam logic [7:0] SyncValue     = 8'hF0;
    localparam logic [7:0] TagAudioByte  = 8'hAF;
    localparam logic [7:0] PktSeqHeader  = 8'h00;
    localparam logic [7:0] PktRawFrame   = 8'h01;
    localparam logic [3:0] HdrSizePlain  = 4'd7;
    localparam logic [3:0] HdrSizeCrc    = 4'd9;

    localparam logic KindSeqHeader = 1'b0;
    localparam logic KindRawFrame  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_kind;
        logic       packet_start;
        logic       packet_end;
        logic       aborted;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  profile;
        logic [3:0]  rate_index;
        logic [2:0]  channels;
        logic        prot_absent;
        logic [12:0] frame_len;
    } t_hdr_fields;

endpackage

`default_nettype wire

FILE: rtl/adts_to_flv_aac_repacketizer_top.sv
// ADTS to FLV AAC audio tag repacketizer.
// The input channel takes one ADTS stream byte per word, with a flag on the
// last byte of each source buffer. The output channel gives the bodies of
// FLV audio tags one byte per word, marked with packet kind, start, end and
// an abort flag on frames that a buffer end cut short.
// An accepted byte is parsed in the cycle it is taken; its results show on
// the output in the next cycle. A payload byte gives one word, so payload
// streams at one byte per cycle unless stalled. The last header byte of a frame
// gives two words (0xAF 0x01), or six on the first frame when the sequence
// header goes first; those words leave from a six-word result buffer, one per
// cycle, and the input stalls until the buffer drains to its last word.
// Reset empties the result buffer, restarts header collection and arms the
// sequence header again. When the receiver stalls, the buffered words hold
// and the input stalls while any word is waiting.
`default_nettype none

module adts_to_flv_aac_repacketizer_top
    import a2flv_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_data
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    localparam int unsigned CntW = $clog2(MaxResults + 1);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hcount, n_hcount;
    t_hdr_fields r_fields, n_fields;
    logic [12:0] r_left, n_left;
    logic        r_seq_sent, n_seq_sent;

    t_out_word   r_buf [MaxResults];
    t_out_word   n_buf [MaxResults];
    logic [CntW-1:0] r_cnt, n_cnt;

    t_out_word   res [MaxResults];
    logic [CntW-1:0] res_cnt;

    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic        bend;
    logic [3:0]  hsize;
    logic        lost;
    logic [12:0] left_calc;
    logic [2:0]  aot;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[0];
    assign pop         = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_cnt > CntW'(1)) || ((r_cnt == CntW'(1)) && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign b           = i_in_data.data_byte;
    assign bend        = i_in_data.buffer_end;

    always_comb begin
        n_phase    = r_phase;
        n_hcount   = r_hcount;
        n_fields   = r_fields;
        n_left     = r_left;
        n_seq_sent = r_seq_sent;
        res_cnt    = '0;
        lost       = 1'b0;
        hsize      = HdrSizeCrc;
        left_calc  = '0;
        aot        = '0;
        for (int i = 0; i < MaxResults; i++) begin
            res[i] = '0;
        end

        case (r_phase)
            PH_DISCARD: begin
                if (bend) begin
                    n_phase  = PH_HEADER;
                    n_hcount = '0;
                    n_fields = '0;
                end
            end
            PH_PAYLOAD: begin
                res[0] = '{out_byte: b, packet_kind: KindRawFrame, packet_start: 1'b0,
                           packet_end: (r_left <= 13'd1) || bend,
                           aborted: bend && (r_left > 13'd1)};
                res_cnt = CntW'(1);
                if (r_left != '0) begin
                    n_left = r_left - 13'd1;
                end
                if ((r_left <= 13'd1) || bend) begin
                    n_left   = '0;
                    n_phase  = PH_HEADER;
                    n_hcount = '0;
                    n_fields = '0;
                end
            end
            default: begin
                case (r_hcount)
                    4'd0: lost = (b != SyncByte);
                    4'd1: begin
                        lost                 = ((b & SyncMask) != SyncValue);
                        n_fields.prot_absent = b[0];
                    end
                    4'd2: begin
                        n_fields.profile     = r_fields.profile | b[7:6];
                        n_fields.rate_index  = r_fields.rate_index | b[5:2];
                        n_fields.channels[2] = r_fields.channels[2] | b[0];
                    end
                    4'd3: begin
                        n_fields.channels[1:0]   = r_fields.channels[1:0] | b[7:6];
                        n_fields.frame_len[12:11] = r_fields.frame_len[12:11] | b[1:0];
                    end
                    4'd4: n_fields.frame_len[10:3] = r_fields.frame_len[10:3] | b;
                    4'd5: n_fields.frame_len[2:0]  = r_fields.frame_len[2:0] | b[7:5];
                    default: ;
                endcase
                hsize = n_fields.prot_absent ? HdrSizePlain : HdrSizeCrc;
                if ((r_hcount == 4'd5) && (n_fields.frame_len < {9'd0, hsize})) begin
                    lost = 1'b1;
                end
                left_calc = n_fields.frame_len - {9'd0, hsize};
                aot       = {1'b0, n_fields.profile} + 3'd1;

                if (lost) begin
                    if (bend) begin
                        n_phase  = PH_HEADER;
                        n_hcount = '0;
                        n_fields = '0;
                    end else begin
                        n_phase = PH_DISCARD;
                    end
                end else if (({1'b0, r_hcount} + 5'd1) >= {1'b0, hsize}) begin
                    t_out_word w_af;
                    t_out_word w_01;
                    w_af = '{out_byte: TagAudioByte, packet_kind: KindRawFrame,
                             packet_start: 1'b1, packet_end: 1'b0, aborted: 1'b0};
                    w_01 = '{out_byte: PktRawFrame, packet_kind: KindRawFrame,
                             packet_start: 1'b0, packet_end: (left_calc == '0) || bend,
                             aborted: (left_calc != '0) && bend};
                    if (!r_seq_sent) begin
                        res[0] = '{out_byte: TagAudioByte, packet_kind: KindSeqHeader,
                                   packet_start: 1'b1, packet_end: 1'b0, aborted: 1'b0};
                        res[1] = '{out_byte: PktSeqHeader, packet_kind: KindSeqHeader,
                                   packet_start: 1'b0, packet_end: 1'b0, aborted: 1'b0};
                        res[2] = '{out_byte: {2'b00, aot, n_fields.rate_index[3:1]},
                                   packet_kind: KindSeqHeader, packet_start: 1'b0,
                                   packet_end: 1'b0, aborted: 1'b0};
                        res[3] = '{out_byte: {n_fields.rate_index[0], 1'b0,
                                              n_fields.channels, 3'b000},
                                   packet_kind: KindSeqHeader, packet_start: 1'b0,
                                   packet_end: 1'b1, aborted: 1'b0};
                        res[4]     = w_af;
                        res[5]     = w_01;
                        res_cnt    = CntW'(6);
                        n_seq_sent = 1'b1;
                    end else begin
                        res[0]  = w_af;
                        res[1]  = w_01;
                        res_cnt = CntW'(2);
                    end
                    if ((left_calc == '0) || bend) begin
                        n_phase  = PH_HEADER;
                        n_hcount = '0;
                        n_fields = '0;
                    end else begin
                        n_left   = left_calc;
                        n_phase  = PH_PAYLOAD;
                        n_hcount = '0;
                    end
                end else if (bend) begin
                    n_phase  = PH_HEADER;
                    n_hcount = '0;
                    n_fields = '0;
                end else begin
                    n_hcount = r_hcount + 4'd1;
                end
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MaxResults; i++) begin
            n_buf[i] = r_buf[i];
        end
        n_cnt = r_cnt;
        if (accept) begin
            for (int i = 0; i < MaxResults; i++) begin
                n_buf[i] = res[i];
            end
            n_cnt = res_cnt;
        end else if (pop) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MaxResults; i++) begin
            r_buf[i] <= n_buf[i];
        end
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hcount   <= '0;
            r_fields   <= '0;
            r_left     <= '0;
            r_seq_sent <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_phase    <= n_phase;
                r_hcount   <= n_hcount;
                r_fields   <= n_fields;
                r_left     <= n_left;
                r_seq_sent <= n_seq_sent;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_adts_to_flv_aac_repacketizer_top.sv
`timescale 1ns / 100ps

module tb_adts_to_flv_aac_repacketizer_top;
    import a2flv_pkg::*;

    typedef enum logic [1:0] {
        PhHeader  = 2'd0,
        PhPayload = 2'd1,
        PhDiscard = 2'd2
    } t_parse_phase;

    typedef enum int {
        FlawNone,
        FlawSyncByte,
        FlawSecondByte,
        FlawNoise
    } t_flaw;

    typedef struct packed {
        t_in_word        word;
        logic            typed;
        logic [1:0]      n_typed;
        t_out_word [1:0] typed_out;
    } t_adts_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;

    t_parse_phase adts_phase;
    logic [3:0]   adts_hdr_count;
    t_hdr_fields  adts_hdr;
    logic [12:0]  payload_left_cnt;
    logic         seq_hdr_sent;

    t_out_word tag_bytes_due[$];
    t_adts_row adts_rows[$];

    logic quiet_tail = 1'b0;
    int   fail_count = 0;
    int   words_checked = 0;
    int   frames_seen = 0;
    int   aborts_seen = 0;
    int   bytes_sent = 0;

    adts_to_flv_aac_repacketizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_out_word tag_byte(input logic [7:0] b, input logic kind,
                                           input logic sop, input logic eop,
                                           input logic ab);
        t_out_word w;
        w.out_byte     = b;
        w.packet_kind  = kind;
        w.packet_start = sop;
        w.packet_end   = eop;
        w.aborted      = ab;
        return w;
    endfunction

    task automatic restart_adts_header();
        adts_phase     = PhHeader;
        adts_hdr_count = '0;
        adts_hdr       = '0;
    endtask

    task automatic predict_tag_bytes(input t_in_word w);
        logic [3:0]  cnt;
        logic [3:0]  hsize;
        logic        lost;
        logic        is_last;
        logic [12:0] left;
        logic [2:0]  aot;
        cnt  = adts_hdr_count;
        lost = 1'b0;
        case (adts_phase)
            PhDiscard: begin
                if (w.buffer_end) begin
                    restart_adts_header();
                end
            end
            PhPayload: begin
                is_last = (payload_left_cnt <= 13'd1);
                tag_bytes_due.push_back(tag_byte(w.data_byte, KindRawFrame, 1'b0,
                                                 is_last || w.buffer_end,
                                                 w.buffer_end && !is_last));
                if (payload_left_cnt != '0) begin
                    payload_left_cnt = payload_left_cnt - 13'd1;
                end
                if (is_last || w.buffer_end) begin
                    payload_left_cnt = '0;
                    restart_adts_header();
                end
            end
            default: begin
                if (cnt == 4'd1) begin
                    adts_hdr.prot_absent = w.data_byte[0];
                end
                hsize = adts_hdr.prot_absent ? HdrSizePlain : HdrSizeCrc;
                case (cnt)
                    4'd0: lost = (w.data_byte != SyncByte);
                    4'd1: lost = ((w.data_byte & SyncMask) != SyncValue);
                    4'd2: begin
                        adts_hdr.profile     = adts_hdr.profile | w.data_byte[7:6];
                        adts_hdr.rate_index  = adts_hdr.rate_index | w.data_byte[5:2];
                        adts_hdr.channels[2] = adts_hdr.channels[2] | w.data_byte[0];
                    end
                    4'd3: begin
                        adts_hdr.channels[1:0] = adts_hdr.channels[1:0] | w.data_byte[7:6];
                        adts_hdr.frame_len[12:11] = adts_hdr.frame_len[12:11]
                                                    | w.data_byte[1:0];
                    end
                    4'd4: adts_hdr.frame_len[10:3] = adts_hdr.frame_len[10:3] | w.data_byte;
                    4'd5: begin
                        adts_hdr.frame_len[2:0] = adts_hdr.frame_len[2:0] | w.data_byte[7:5];
                        lost = (adts_hdr.frame_len < {9'd0, hsize});
                    end
                    default: ;
                endcase

                if (lost) begin
                    if (w.buffer_end) begin
                        restart_adts_header();
                    end else begin
                        adts_phase = PhDiscard;
                    end
                end else if ({1'b0, cnt} + 5'd1 >= {1'b0, hsize}) begin
                    left = adts_hdr.frame_len - {9'd0, hsize};
                    if (!seq_hdr_sent) begin
                        aot = {1'b0, adts_hdr.profile} + 3'd1;
                        tag_bytes_due.push_back(tag_byte(TagAudioByte, KindSeqHeader,
                                                         1'b1, 1'b0, 1'b0));
                        tag_bytes_due.push_back(tag_byte(PktSeqHeader, KindSeqHeader,
                                                         1'b0, 1'b0, 1'b0));
                        tag_bytes_due.push_back(tag_byte({2'b00, aot,
                                                          adts_hdr.rate_index[3:1]},
                                                         KindSeqHeader, 1'b0, 1'b0, 1'b0));
                        tag_bytes_due.push_back(tag_byte({adts_hdr.rate_index[0], 1'b0,
                                                          adts_hdr.channels, 3'b000},
                                                         KindSeqHeader, 1'b0, 1'b1, 1'b0));
                        seq_hdr_sent = 1'b1;
                    end
                    tag_bytes_due.push_back(tag_byte(TagAudioByte, KindRawFrame,
                                                     1'b1, 1'b0, 1'b0));
                    if (left == '0) begin
                        tag_bytes_due.push_back(tag_byte(PktRawFrame, KindRawFrame,
                                                         1'b0, 1'b1, 1'b0));
                        restart_adts_header();
                    end else if (w.buffer_end) begin
                        tag_bytes_due.push_back(tag_byte(PktRawFrame, KindRawFrame,
                                                         1'b0, 1'b1, 1'b1));
                        restart_adts_header();
                    end else begin
                        tag_bytes_due.push_back(tag_byte(PktRawFrame, KindRawFrame,
                                                         1'b0, 1'b0, 1'b0));
                        payload_left_cnt = left;
                        adts_phase       = PhPayload;
                        adts_hdr_count   = '0;
                    end
                end else if (w.buffer_end) begin
                    restart_adts_header();
                end else begin
                    adts_hdr_count = cnt + 4'd1;
                end
            end
        endcase
    endtask

    task automatic typed_row(input logic [7:0] b, input logic bend, input logic [1:0] n,
                             input t_out_word e0, input t_out_word e1);
        t_adts_row row;
        row.word.data_byte  = b;
        row.word.buffer_end = bend;
        row.typed           = 1'b1;
        row.n_typed         = n;
        row.typed_out[0]    = e0;
        row.typed_out[1]    = e1;
        adts_rows.push_back(row);
    endtask

    task automatic silent_row(input logic [7:0] b, input logic bend);
        typed_row(b, bend, 2'd0, '0, '0);
    endtask

    task automatic plain_row(input logic [7:0] b, input logic bend);
        t_adts_row row;
        row                 = '0;
        row.word.data_byte  = b;
        row.word.buffer_end = bend;
        adts_rows.push_back(row);
    endtask

    task automatic queue_adts_frame(input logic crc, input logic [12:0] flen,
                                    input int n_bytes, input logic end_flag,
                                    input t_flaw flaw);
        logic [7:0] b;
        int         i;
        for (i = 0; i < n_bytes; i++) begin
            b = 8'($urandom_range(0, 255));
            if (flaw != FlawNoise) begin
                case (i)
                    0: b = SyncByte;
                    1: b = {4'hF, b[3], 2'b00, ~crc};
                    3: b = {b[7:2], flen[12:11]};
                    4: b = flen[10:3];
                    5: b = {flen[2:0], b[4:0]};
                    default: ;
                endcase
            end
            if (flaw == FlawSyncByte && i == 0) begin
                while (b == SyncByte) b = 8'($urandom_range(0, 255));
            end
            if (flaw == FlawSecondByte && i == 1) begin
                while ((b & SyncMask) == SyncValue) b = 8'($urandom_range(0, 255));
            end
            plain_row(b, end_flag && (i == n_bytes - 1));
        end
    endtask

    task automatic queue_random_adts(input int want);
        int   counted;
        int   pick;
        int   hsz;
        int   n;
        int   cut;
        int   nb;
        logic crc;
        counted = 0;
        while (counted < want) begin
            pick = int'($urandom_range(0, 99));
            crc  = 1'($urandom_range(0, 1));
            hsz  = crc ? 9 : 7;
            if (pick < 70) begin
                pick = int'($urandom_range(0, 99));
                cut  = -1;
                if (pick < 12) begin
                    n = hsz;
                end else if (pick < 88) begin
                    n = hsz + int'($urandom_range(1, 8));
                end else begin
                    n   = int'($urandom_range(hsz + 20, 8191));
                    cut = hsz - 1 + int'($urandom_range(0, 10));
                end
                if (cut < 0 && $urandom_range(0, 4) == 0) begin
                    cut = int'($urandom_range(0, n - 1));
                end
                if (cut >= 0) begin
                    queue_adts_frame(crc, 13'(n), cut + 1, 1'b1, FlawNone);
                    counted += cut + 1;
                end else begin
                    queue_adts_frame(crc, 13'(n), n, ($urandom_range(0, 3) == 0), FlawNone);
                    counted += n;
                end
            end else if (pick < 82) begin
                nb = int'($urandom_range(2, 12));
                queue_adts_frame(crc, 13'($urandom_range(0, 8191)), nb, 1'b1,
                                 ($urandom_range(0, 1) == 0) ? FlawSyncByte : FlawSecondByte);
                counted += nb;
            end else if (pick < 92) begin
                nb = int'($urandom_range(6, 12));
                queue_adts_frame(crc, 13'($urandom_range(0, hsz - 1)), nb, 1'b1, FlawNone);
                counted += nb;
            end else begin
                nb = int'($urandom_range(1, 4));
                queue_adts_frame(crc, '0, nb, 1'b1, FlawNoise);
                counted += nb;
            end
        end
    endtask

    task automatic check_tag_byte(input t_out_word got);
        t_out_word want;
        words_checked++;
        if (got.packet_start && got.packet_kind == KindRawFrame) frames_seen++;
        if (got.aborted) aborts_seen++;
        if (tag_bytes_due.size() == 0) begin
            $error("unexpected word: out_byte %h kind %b start %b end %b aborted %b",
                   got.out_byte, got.packet_kind, got.packet_start, got.packet_end,
                   got.aborted);
            fail_count++;
        end else begin
            want = tag_bytes_due.pop_front();
            if (got.out_byte != want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.packet_kind != want.packet_kind) begin
                $error("packet_kind: expected %b, got %b", want.packet_kind, got.packet_kind);
                fail_count++;
            end
            if (got.packet_start != want.packet_start) begin
                $error("packet_start: expected %b, got %b", want.packet_start,
                       got.packet_start);
                fail_count++;
            end
            if (got.packet_end != want.packet_end) begin
                $error("packet_end: expected %b, got %b", want.packet_end, got.packet_end);
                fail_count++;
            end
            if (got.aborted != want.aborted) begin
                $error("aborted: expected %b, got %b", want.aborted, got.aborted);
                fail_count++;
            end
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                check_tag_byte(o_out_data);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = int'($urandom_range(1, 15)) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_adts_row row;
        int        idx;
        int        k;
        int        n_before;
        int        n_directed;

        seq_hdr_sent     = 1'b0;
        payload_left_cnt = '0;
        restart_adts_header();

        // A byte other than the sync byte starts a discard up to the buffer end.
        silent_row(8'h00, 1'b0);
        silent_row(8'h55, 1'b1);
        // First frame: reserved rate index, seven channels, three payload bytes,
        // cut short by a buffer end on the second one.
        silent_row(8'hFF, 1'b0);
        silent_row(8'hF1, 1'b0);
        silent_row(8'hFD, 1'b0);
        silent_row(8'hC0, 1'b0);
        silent_row(8'h01, 1'b0);
        silent_row(8'h40, 1'b0);
        plain_row(8'hFC, 1'b0);
        typed_row(8'h00, 1'b0, 2'd1, tag_byte(8'h00, KindRawFrame, 1'b0, 1'b0, 1'b0), '0);
        typed_row(8'hFF, 1'b1, 2'd1, tag_byte(8'hFF, KindRawFrame, 1'b0, 1'b1, 1'b1), '0);
        // CRC header whose last byte ends the buffer while payload remains.
        silent_row(8'hFF, 1'b0);
        silent_row(8'hF0, 1'b0);
        silent_row(8'h50, 1'b0);
        silent_row(8'h80, 1'b0);
        silent_row(8'h02, 1'b0);
        silent_row(8'h1F, 1'b0);
        silent_row(8'h00, 1'b0);
        silent_row(8'hA5, 1'b0);
        typed_row(8'h3C, 1'b1, 2'd2,
                  tag_byte(TagAudioByte, KindRawFrame, 1'b1, 1'b0, 1'b0),
                  tag_byte(PktRawFrame, KindRawFrame, 1'b0, 1'b1, 1'b1));
        // Frame length of zero is shorter than any header; the bad byte ends the buffer.
        silent_row(8'hFF, 1'b0);
        silent_row(8'hF1, 1'b0);
        silent_row(8'h00, 1'b0);
        silent_row(8'h00, 1'b0);
        silent_row(8'h00, 1'b0);
        silent_row(8'h00, 1'b1);
        n_directed = adts_rows.size();

        queue_random_adts(210 - n_directed);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < adts_rows.size(); idx++) begin
            row        = adts_rows[idx];
            quiet_tail = (idx + 40 >= adts_rows.size());
            if (idx == n_directed) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (tag_bytes_due.size() != 0);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= row.word;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            bytes_sent++;
            n_before = tag_bytes_due.size();
            predict_tag_bytes(row.word);
            if (row.typed) begin
                while (tag_bytes_due.size() > n_before) void'(tag_bytes_due.pop_back());
                for (k = 0; k < int'(row.n_typed); k++) begin
                    tag_bytes_due.push_back(row.typed_out[k]);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (tag_bytes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Fed %0d ADTS bytes and checked %0d tag body words.",
                 bytes_sent, words_checked);
        $display("Frame packets seen: %0d, of which %0d were cut short by a buffer end.",
                 frames_seen, aborts_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
